FILE: hdl/cmt_pkg.sv
package cmt_pkg;

    // Fixed-point and sizing constants
    localparam int FRAC_BITS   = 14;
    localparam int PHASE_W     = 10;
    localparam int QTR_W       = 8;
    localparam int TAB_DEPTH   = 1 << QTR_W;
    localparam int ROW_W       = 8;
    localparam int SEG_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int DIV_NUM_W   = 24;
    localparam int DIV_DEN_W   = 10;
    localparam int DIV_QUO_W   = 15;
    localparam int DIV_CNT_W   = 4;
    localparam int NUM_CAPS    = 8;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    // Taylor term denominators (2n)(2n+1) and (2n-1)(2n)
    localparam longint unsigned SIN_DEN [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned COS_DEN [7] = '{2, 12, 30, 56, 90, 132, 182};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd1;

    // Surface codes
    typedef enum logic [1:0] {
        SURF_SIDE   = 2'd0,
        SURF_TOP    = 2'd1,
        SURF_BOTTOM = 2'd2
    } t_surface;

    typedef logic signed [15:0] t_fix;

    localparam t_fix VAL_ONE  = 16'sd16384;
    localparam t_fix VAL_HALF = 16'sd8192;

    // One finished cell: every distinct value the 18 vertices need
    typedef struct packed {
        logic err;
        t_fix lx;
        t_fix lz;
        t_fix rx;
        t_fix rz;
        t_fix nlx;
        t_fix nlz;
        t_fix nrx;
        t_fix nrz;
        t_fix ytop;
        t_fix ybot;
        t_fix tlx;
        t_fix tlz;
        t_fix trx;
        t_fix trz;
        t_fix blx;
        t_fix blz;
        t_fix brx;
        t_fix brz;
    } t_cell;

    // Front to queue write
    typedef struct packed {
        logic  wr;
        t_cell data;
    } t_cell_wr;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_sc;

    typedef logic signed [31:0] t_trig_tab [TAB_DEPTH];

    // First-quadrant sine or cosine in Q30, built at elaboration
    function automatic t_trig_tab f_build_tab(input logic want_cos);
        t_trig_tab         tab;
        longint unsigned   r;
        longint unsigned   ts;
        longint unsigned   tc;
        longint            s;
        longint            c;
        for (int t = 0; t < TAB_DEPTH; t++) begin
            r  = (64'(t) * HALF_PI_Q30) >> QTR_W;
            ts = r;
            tc = Q30_ONE;
            s  = longint'(r);
            c  = longint'(Q30_ONE);
            for (int n = 0; n < 7; n++) begin
                ts = ((((ts * r) >> 30) * r) >> 30) / SIN_DEN[n];
                tc = ((((tc * r) >> 30) * r) >> 30) / COS_DEN[n];
                if ((n & 1) == 0) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s > longint'(Q30_ONE)) s = longint'(Q30_ONE);
            if (s < -longint'(Q30_ONE)) s = -longint'(Q30_ONE);
            if (c > longint'(Q30_ONE)) c = longint'(Q30_ONE);
            if (c < -longint'(Q30_ONE)) c = -longint'(Q30_ONE);
            tab[t] = want_cos ? 32'(c) : 32'(s);
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_TAB = f_build_tab(1'b0);
    localparam t_trig_tab COS_TAB = f_build_tab(1'b1);

    // Full-circle sine/cosine by quadrant folding
    function automatic t_sc f_sincos(input logic [PHASE_W-1:0] p);
        t_sc                res;
        logic signed [31:0] s0;
        logic signed [31:0] c0;
        s0 = SIN_TAB[p[QTR_W-1:0]];
        c0 = COS_TAB[p[QTR_W-1:0]];
        case (p[PHASE_W-1:QTR_W])
            2'd0: begin
                res.s = s0;
                res.c = c0;
            end
            2'd1: begin
                res.s = c0;
                res.c = -s0;
            end
            2'd2: begin
                res.s = -s0;
                res.c = -c0;
            end
            default: begin
                res.s = -c0;
                res.c = s0;
            end
        endcase
        return res;
    endfunction

endpackage

FILE: hdl/cylinder_mesh_tessellator_top.sv
// Cylinder cell tessellator. A start transfer names one cell (row, wedge); the block
// returns 18 vertices (side quad, top cap piece, bottom cap piece), one per cycle on
// o_strobe, with o_last on the 18th, or a single o_index_error result when an index is
// at or beyond the configured counts. The receiver cannot stall: every strobe must be
// taken. The one-vertex-per-cycle output sequencer sets the sustained rate; the front
// accepts a new cell once its phase stage hands over, which waits for the phase
// dividers and for room further down, and a two-entry queue decouples the two. busy
// is high while the phase stage holds a cell it is not handing over. Config writes
// are always ready and take effect for items started afterwards; write them only
// while the block is idle.
module cylinder_mesh_tessellator_top
    import cmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ROW_W-1:0]      i_row_index,
    input  logic [SEG_W-1:0]      i_wedge_index,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic [1:0]            o_surface,
    output logic [15:0]           o_pos_x,
    output logic [15:0]           o_pos_y,
    output logic [15:0]           o_pos_z,
    output logic [15:0]           o_norm_x,
    output logic [15:0]           o_norm_y,
    output logic [15:0]           o_norm_z,
    output logic                  o_index_error,
    output logic                  o_last
);

    t_cell_wr q_wr;
    t_cell    q_head;
    logic     q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    cmt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(start), .o_busy(busy),
        .i_row_index(i_row_index), .i_wedge_index(i_wedge_index),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_q_full(q_full), .o_q_wr(q_wr)
    );

    cmt_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(q_wr), .o_full(q_full),
        .i_rd(q_pop), .o_rdata(q_head), .o_empty(q_empty)
    );

    cmt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cell(q_head), .i_empty(q_empty), .o_pop(q_pop),
        .o_strobe(o_strobe), .o_surface(o_surface),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_norm_x(o_norm_x), .o_norm_y(o_norm_y), .o_norm_z(o_norm_z),
        .o_index_error(o_index_error), .o_last(o_last)
    );

endmodule

FILE: hdl/cmt_div.sv
module cmt_div
    import cmt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic [DIV_QUO_W-1:0] o_quo
);

    // Restoring divider, one quotient bit per cycle.
    // Caller guarantees quotient < 2**DIV_QUO_W.
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_QUO_W-1:0] r_sh;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {r_rem, r_sh[DIV_QUO_W-1]} - {1'b0, r_den};
    assign fits  = ({r_rem, r_sh[DIV_QUO_W-1]} >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_QUO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[DIV_NUM_W-1:DIV_QUO_W]};
            r_sh  <= i_num[DIV_QUO_W-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? trial[DIV_DEN_W-1:0]
                          : {r_rem[DIV_DEN_W-2:0], r_sh[DIV_QUO_W-1]};
            r_sh  <= {r_sh[DIV_QUO_W-2:0], fits};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_sh;

endmodule

FILE: hdl/cmt_front.sv
module cmt_front
    import cmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [ROW_W-1:0]      i_row_index,
    input  logic [SEG_W-1:0]      i_wedge_index,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_full,
    output t_cell_wr              o_q_wr
);

    // Magnitude of a Q30 value
    function automatic logic [30:0] f_mag(input logic signed [31:0] v);
        logic signed [31:0] a;
        a = v[31] ? -v : v;
        return a[30:0];
    endfunction

    // Signed result from a magnitude quotient
    function automatic t_fix f_sign(input logic neg, input logic [DIV_QUO_W-1:0] q);
        t_fix v;
        v = t_fix'({1'b0, q});
        return neg ? -v : v;
    endfunction

    // Configuration registers
    logic [ROW_W-1:0] r_row_cnt;
    logic [SEG_W-1:0] r_seg_cnt;
    logic [ROW_W-1:0] row_eff;
    logic [SEG_W-1:0] seg_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= ROW_W'(1);
            r_seg_cnt <= SEG_W'(3);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ROW_COUNT) r_row_cnt <= i_cfg_data[ROW_W-1:0];
            if (i_cfg_index == REG_SEGMENT_COUNT) r_seg_cnt <= i_cfg_data[SEG_W-1:0];
        end
    end

    assign row_eff = (r_row_cnt == '0) ? ROW_W'(1) : r_row_cnt;
    assign seg_eff = (r_seg_cnt < SEG_W'(3)) ? SEG_W'(3) : r_seg_cnt;

    // Stage handshake
    logic r_v1, r_v2a, r_v2b, r_v3;
    logic done1, done3;
    logic take1, take2a, take2b, take3;
    logic free2a, free2b, free3;
    logic accept, in_err;
    logic busy_p0, busy_p1;
    logic [NUM_CAPS+1:0] busy_d;

    assign take3  = done3 && !i_q_full;
    assign free3  = !r_v3 || take3;
    assign take2b = r_v2b && free3;
    assign free2b = !r_v2b || take2b;
    assign take2a = r_v2a && free2b;
    assign free2a = !r_v2a || take2a;
    assign done1  = r_v1 && !busy_p0 && !busy_p1;
    assign take1  = done1 && free2a;
    assign o_busy = r_v1 && !take1;
    assign accept = i_start && !o_busy;
    assign in_err = (i_row_index >= row_eff) || (i_wedge_index >= seg_eff);

    // Stage 1: classify and divide wedge edges into table phases
    logic             r_err1;
    logic [ROW_W-1:0] r_i1;
    logic [ROW_W-1:0] r_r1;
    logic [DIV_NUM_W-1:0] p0_num, p1_num;
    logic [DIV_QUO_W-1:0] p0_q, p1_q;
    logic p_start;

    assign p_start = accept && !in_err;
    assign p0_num  = (DIV_NUM_W'(i_wedge_index) << PHASE_W) + DIV_NUM_W'(seg_eff[SEG_W-1:1]);
    assign p1_num  = ((DIV_NUM_W'(i_wedge_index) + DIV_NUM_W'(1)) << PHASE_W)
                   + DIV_NUM_W'(seg_eff[SEG_W-1:1]);

    cmt_div u_div_p0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(p_start), .i_num(p0_num),
        .i_den(DIV_DEN_W'(seg_eff)), .o_busy(busy_p0), .o_quo(p0_q)
    );
    cmt_div u_div_p1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(p_start), .i_num(p1_num),
        .i_den(DIV_DEN_W'(seg_eff)), .o_busy(busy_p1), .o_quo(p1_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (take1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err1 <= in_err;
            r_i1   <= i_row_index;
            r_r1   <= row_eff;
        end
    end

    // Stage 2a: sine/cosine lookup
    logic             r_err2a;
    logic [ROW_W-1:0] r_i2a;
    logic [ROW_W-1:0] r_r2a;
    t_sc              r_scl, r_scr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2a <= 1'b0;
        end else if (take1) begin
            r_v2a <= 1'b1;
        end else if (take2a) begin
            r_v2a <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_err2a <= r_err1;
            r_i2a   <= r_i1;
            r_r2a   <= r_r1;
            r_scl   <= f_sincos(p0_q[PHASE_W-1:0]);
            r_scr   <= f_sincos(p1_q[PHASE_W-1:0]);
        end
    end

    // Stage 2b: scale by ring radius, side values, divider numerators
    logic signed [31:0]   cap_val [NUM_CAPS];
    logic [ROW_W:0]       cap_mul [NUM_CAPS];
    logic [DIV_NUM_W-1:0] cap_num [NUM_CAPS];
    logic [NUM_CAPS-1:0]  cap_neg;
    logic [39:0]          cap_prod [NUM_CAPS];
    logic signed [10:0]   y_d [2];
    logic [DIV_NUM_W-1:0] y_num [2];
    logic [1:0]           y_neg;
    logic signed [31:0]   side_val [4];
    t_fix                 side_pos [4];
    t_fix                 side_nrm [4];

    logic                 r_err2b;
    logic [ROW_W-1:0]     r_r2b;
    logic [DIV_NUM_W-1:0] r_cap_num [NUM_CAPS];
    logic [NUM_CAPS-1:0]  r_cap_neg2b;
    logic [DIV_NUM_W-1:0] r_y_num [2];
    logic [1:0]           r_y_neg2b;
    t_fix                 r_pos2b [4];
    t_fix                 r_nrm2b [4];

    // Cap order: tlx tlz trx trz blx blz brx brz
    assign cap_val[0] = r_scl.s;
    assign cap_val[1] = r_scl.c;
    assign cap_val[2] = r_scr.s;
    assign cap_val[3] = r_scr.c;
    assign cap_val[4] = r_scl.s;
    assign cap_val[5] = r_scl.c;
    assign cap_val[6] = r_scr.s;
    assign cap_val[7] = r_scr.c;

    // Side order: left x, left z, right x, right z
    assign side_val[0] = r_scl.s;
    assign side_val[1] = r_scl.c;
    assign side_val[2] = r_scr.s;
    assign side_val[3] = r_scr.c;

    always_comb begin
        for (int k = 0; k < NUM_CAPS; k++) begin
            cap_mul[k]  = (k < 4) ? {1'b0, r_i2a} : ({1'b0, r_i2a} + 9'd1);
            cap_prod[k] = 40'(f_mag(cap_val[k])) * 40'(cap_mul[k])
                        + (40'(r_r2a) << 16);
            cap_num[k]  = DIV_NUM_W'(cap_prod[k] >> 17);
            cap_neg[k]  = cap_val[k][31];
        end
        for (int k = 0; k < 4; k++) begin
            side_pos[k] = t_fix'((32'(f_mag(side_val[k])) + 32'd65536) >> 17);
            side_nrm[k] = t_fix'((32'(f_mag(side_val[k])) + 32'd32768) >> 16);
            if (side_val[k][31]) begin
                side_pos[k] = -side_pos[k];
                side_nrm[k] = -side_nrm[k];
            end
        end
        y_d[0] = 11'(r_r2a) - (11'(r_i2a) << 1);
        y_d[1] = y_d[0] - 11'sd2;
        for (int k = 0; k < 2; k++) begin
            y_neg[k] = y_d[k][10];
            y_num[k] = ((DIV_NUM_W'(y_neg[k] ? -y_d[k] : y_d[k]) << FRAC_BITS)
                     + DIV_NUM_W'(r_r2a)) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2b <= 1'b0;
        end else if (take2a) begin
            r_v2b <= 1'b1;
        end else if (take2b) begin
            r_v2b <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take2a) begin
            r_err2b     <= r_err2a;
            r_r2b       <= r_r2a;
            r_cap_num   <= cap_num;
            r_cap_neg2b <= cap_neg;
            r_y_num     <= y_num;
            r_y_neg2b   <= y_neg;
            r_pos2b     <= side_pos;
            r_nrm2b     <= side_nrm;
        end
    end

    // Stage 3: divide cap and height values by the row count
    logic                 r_err3;
    logic [NUM_CAPS-1:0]  r_cap_neg3;
    logic [1:0]           r_y_neg3;
    t_fix                 r_pos3 [4];
    t_fix                 r_nrm3 [4];
    logic [DIV_QUO_W-1:0] cap_q [NUM_CAPS];
    logic [DIV_QUO_W-1:0] y_q [2];
    logic                 d_start;

    assign d_start = take2b && !r_err2b;

    for (genvar g = 0; g < NUM_CAPS; g++) begin : g_cap_div
        cmt_div u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
            .i_num(r_cap_num[g]), .i_den(DIV_DEN_W'(r_r2b)),
            .o_busy(busy_d[g]), .o_quo(cap_q[g])
        );
    end

    for (genvar g = 0; g < 2; g++) begin : g_y_div
        cmt_div u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
            .i_num(r_y_num[g]), .i_den(DIV_DEN_W'(r_r2b)),
            .o_busy(busy_d[NUM_CAPS+g]), .o_quo(y_q[g])
        );
    end

    assign done3 = r_v3 && (busy_d == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (take2b) begin
            r_v3 <= 1'b1;
        end else if (take3) begin
            r_v3 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take2b) begin
            r_err3     <= r_err2b;
            r_cap_neg3 <= r_cap_neg2b;
            r_y_neg3   <= r_y_neg2b;
            r_pos3     <= r_pos2b;
            r_nrm3     <= r_nrm2b;
        end
    end

    // Queue write
    always_comb begin
        o_q_wr.wr        = take3;
        o_q_wr.data.err  = r_err3;
        o_q_wr.data.lx   = r_pos3[0];
        o_q_wr.data.lz   = r_pos3[1];
        o_q_wr.data.rx   = r_pos3[2];
        o_q_wr.data.rz   = r_pos3[3];
        o_q_wr.data.nlx  = r_nrm3[0];
        o_q_wr.data.nlz  = r_nrm3[1];
        o_q_wr.data.nrx  = r_nrm3[2];
        o_q_wr.data.nrz  = r_nrm3[3];
        o_q_wr.data.ytop = f_sign(r_y_neg3[0], y_q[0]);
        o_q_wr.data.ybot = f_sign(r_y_neg3[1], y_q[1]);
        o_q_wr.data.tlx  = f_sign(r_cap_neg3[0], cap_q[0]);
        o_q_wr.data.tlz  = f_sign(r_cap_neg3[1], cap_q[1]);
        o_q_wr.data.trx  = f_sign(r_cap_neg3[2], cap_q[2]);
        o_q_wr.data.trz  = f_sign(r_cap_neg3[3], cap_q[3]);
        o_q_wr.data.blx  = f_sign(r_cap_neg3[4], cap_q[4]);
        o_q_wr.data.blz  = f_sign(r_cap_neg3[5], cap_q[5]);
        o_q_wr.data.brx  = f_sign(r_cap_neg3[6], cap_q[6]);
        o_q_wr.data.brz  = f_sign(r_cap_neg3[7], cap_q[7]);
    end

`ifndef ASSERT_OFF
    // Stage 1 never hands over while its phase dividers still run
    a_take1_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take1 |-> !busy_p0 && !busy_p1)
        else $error("phase handed over while dividing");
    // Never write a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_wr.wr |-> !i_q_full)
        else $error("queue overflow");
    // An accepted error item starts no divider
    a_err_nodiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_err |=> !busy_p0)
        else $error("error item started phase divider");
`endif

endmodule

FILE: hdl/cmt_fifo.sv
module cmt_fifo
    import cmt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cell_wr i_wr,
    output logic     o_full,
    input  logic     i_rd,
    output t_cell    o_rdata,
    output logic     o_empty
);

    // Two-entry queue of finished cells
    t_cell      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr.wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            case ({i_wr.wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr) r_mem[r_wp] <= i_wr.data;
    end

endmodule

FILE: hdl/cmt_back.sv
module cmt_back
    import cmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell       i_cell,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [1:0]  o_surface,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic [15:0] o_pos_z,
    output logic [15:0] o_norm_x,
    output logic [15:0] o_norm_y,
    output logic [15:0] o_norm_z,
    output logic        o_index_error,
    output logic        o_last
);

    t_surface   r_piece;
    logic [2:0] r_corner;
    logic       r_strobe, r_err, r_last;
    t_surface   r_surf;
    t_fix       r_px, r_py, r_pz, r_nx, r_ny, r_nz;

    logic is_right, is_bot, piece_end, cell_end;
    t_fix n_px, n_py, n_pz, n_nx, n_ny, n_nz;
    t_fix cap_x, cap_z;

    // Corner order in each piece: TL BL TR TR BL BR (left and right swapped in the bottom piece)
    assign is_bot    = (r_corner == 3'd1) || (r_corner == 3'd4) || (r_corner == 3'd5);
    assign piece_end = (r_corner == 3'd5);
    assign cell_end  = i_cell.err || (piece_end && (r_piece == SURF_BOTTOM));
    assign o_pop     = !i_empty && cell_end;

    always_comb begin
        is_right = (r_corner == 3'd2) || (r_corner == 3'd3) || (r_corner == 3'd5);
        if (r_piece == SURF_BOTTOM) is_right = !is_right;
        case ({is_bot, is_right})
            2'b00:   begin cap_x = i_cell.tlx; cap_z = i_cell.tlz; end
            2'b01:   begin cap_x = i_cell.trx; cap_z = i_cell.trz; end
            2'b10:   begin cap_x = i_cell.blx; cap_z = i_cell.blz; end
            default: begin cap_x = i_cell.brx; cap_z = i_cell.brz; end
        endcase
        case (r_piece)
            SURF_SIDE: begin
                n_px = is_right ? i_cell.rx : i_cell.lx;
                n_pz = is_right ? i_cell.rz : i_cell.lz;
                n_py = is_bot ? i_cell.ybot : i_cell.ytop;
                n_nx = is_right ? i_cell.nrx : i_cell.nlx;
                n_nz = is_right ? i_cell.nrz : i_cell.nlz;
                n_ny = '0;
            end
            SURF_TOP: begin
                n_px = cap_x;
                n_pz = cap_z;
                n_py = VAL_HALF;
                n_nx = '0;
                n_nz = '0;
                n_ny = VAL_ONE;
            end
            default: begin
                n_px = cap_x;
                n_pz = cap_z;
                n_py = -VAL_HALF;
                n_nx = '0;
                n_nz = '0;
                n_ny = -VAL_ONE;
            end
        endcase
    end

    // Vertex sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piece  <= SURF_SIDE;
            r_corner <= 3'd0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= !i_empty;
            if (!i_empty) begin
                if (cell_end) begin
                    r_piece  <= SURF_SIDE;
                    r_corner <= 3'd0;
                end else if (piece_end) begin
                    r_corner <= 3'd0;
                    r_piece  <= (r_piece == SURF_SIDE) ? SURF_TOP : SURF_BOTTOM;
                end else begin
                    r_corner <= r_corner + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_err  <= i_cell.err;
        r_last <= cell_end;
        r_surf <= i_cell.err ? SURF_SIDE : r_piece;
        r_px   <= i_cell.err ? '0 : n_px;
        r_py   <= i_cell.err ? '0 : n_py;
        r_pz   <= i_cell.err ? '0 : n_pz;
        r_nx   <= i_cell.err ? '0 : n_nx;
        r_ny   <= i_cell.err ? '0 : n_ny;
        r_nz   <= i_cell.err ? '0 : n_nz;
    end

    assign o_strobe      = r_strobe;
    assign o_surface     = r_surf;
    assign o_pos_x       = r_px;
    assign o_pos_y       = r_py;
    assign o_pos_z       = r_pz;
    assign o_norm_x      = r_nx;
    assign o_norm_y      = r_ny;
    assign o_norm_z      = r_nz;
    assign o_index_error = r_err;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    // An error result is a single, final result
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_index_error |-> o_last)
        else $error("error result not last");
    // A new cell only starts after the previous one ended
    a_new_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(o_strobe) && (o_surface == SURF_SIDE)
        && ($past(o_surface) == SURF_BOTTOM) |-> $past(o_last))
        else $error("cell cut short");
    // The sequencer stays parked at the first corner while the queue is empty
    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |=> $stable(r_corner) && $stable(r_piece))
        else $error("sequencer moved without a cell");
`endif

endmodule

FILE: dv/tb_cylinder_mesh_tessellator_top.sv
module tb_cylinder_mesh_tessellator_top;
    import cmt_pkg::*;

    localparam int          WDOG_LIMIT  = 5000;
    localparam int          SETTLE_CYC  = 80;
    localparam int          MAX_REPORTS = 10;
    localparam int          CELL_VERTS  = 18;
    localparam int          TAB_SIZE    = 1024;
    localparam int          ROW_MAX     = 255;
    localparam int          SEG_MAX     = 1023;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [SEG_W-1:0] wedge;
    } cell_req_t;

    typedef struct packed {
        logic [1:0]  surf;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        err;
        logic        last;
    } vertex_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [ROW_W-1:0]      i_row_index;
    logic [SEG_W-1:0]      i_wedge_index;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_strobe;
    logic [1:0]            o_surface;
    logic [15:0]           o_pos_x;
    logic [15:0]           o_pos_y;
    logic [15:0]           o_pos_z;
    logic [15:0]           o_norm_x;
    logic [15:0]           o_norm_y;
    logic [15:0]           o_norm_z;
    logic                  o_index_error;
    logic                  o_last;

    cell_req_t   cell_q[$];
    vertex_t     vertex_q[$];
    logic [7:0]  row_cfg;
    logic [9:0]  seg_cfg;
    int          idle_pct;
    int          mismatches;
    int          quiet_cyc;

    cylinder_mesh_tessellator_top DUT (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Divide, rounding halves away from zero
    function automatic longint round_div(input longint n, input longint unsigned d);
        longint unsigned m;
        longint unsigned q;
        m = (n < 0) ? longint'(-n) : longint'(n);
        q = (m + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unit_clip(input longint v);
        if (v > longint'(Q30_ONE)) return longint'(Q30_ONE);
        if (v < -longint'(Q30_ONE)) return -longint'(Q30_ONE);
        return v;
    endfunction

    // Q30 sine/cosine of phase p out of a full circle of TAB_SIZE steps
    task automatic phase_trig(input longint unsigned p, output longint s_o,
                              output longint c_o);
        longint unsigned ang, quad, r, ts, tc;
        longint          s, c;
        ang  = p * 4 * HALF_PI_Q30 / TAB_SIZE;
        quad = ang / HALF_PI_Q30;
        r    = ang - quad * HALF_PI_Q30;
        ts   = r;
        tc   = Q30_ONE;
        s    = longint'(r);
        c    = longint'(Q30_ONE);
        for (int n = 1; n <= 7; n++) begin
            ts = ((((ts * r) >> 30) * r) >> 30) / ((2 * n) * (2 * n + 1));
            tc = ((((tc * r) >> 30) * r) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                s -= longint'(ts);
                c -= longint'(tc);
            end else begin
                s += longint'(ts);
                c += longint'(tc);
            end
        end
        s = unit_clip(s);
        c = unit_clip(c);
        case (quad % 4)
            0: begin s_o = s;  c_o = c;  end
            1: begin s_o = c;  c_o = -s; end
            2: begin s_o = -s; c_o = -c; end
            default: begin s_o = -c; c_o = s; end
        endcase
    endtask

    function automatic void push_vertex(input t_surface sf, input longint px, input longint py,
                                        input longint pz, input longint nx, input longint ny,
                                        input longint nz, input logic lst);
        vertex_t v;
        v.surf = sf;
        v.px = 16'(px); v.py = 16'(py); v.pz = 16'(pz);
        v.nx = 16'(nx); v.ny = 16'(ny); v.nz = 16'(nz);
        v.err = 1'b0;
        v.last = lst;
        vertex_q.insert(vertex_q.size(), v);
    endfunction

    // Expected vertices of one cell
    task automatic tessellate_cell(input logic [ROW_W-1:0] row, input logic [SEG_W-1:0] wedge);
        longint unsigned rr, ss, i, j, p0, p1, sh;
        longint          sl, cl, sr, cr, one, half;
        longint          lx, lz, rx, rz, nlx, nlz, nrx, nrz, yt, yb;
        longint          tlx, tlz, trx, trz, blx, blz, brx, brz;
        vertex_t         ev;
        rr = row_cfg;
        ss = seg_cfg;
        i  = row;
        j  = wedge;
        if (rr < 1) rr = 1;
        if (rr > ROW_MAX) rr = ROW_MAX;
        if (ss < 3) ss = 3;
        if (ss > SEG_MAX) ss = SEG_MAX;
        if (i >= rr || j >= ss) begin
            ev = '0;
            ev.err = 1'b1;
            ev.last = 1'b1;
            vertex_q.insert(vertex_q.size(), ev);
            return;
        end
        sh = 64'd1 << (30 - FRAC_BITS);
        p0 = ((j * TAB_SIZE * 2 + ss) / (2 * ss)) % TAB_SIZE;
        p1 = (((j + 1) * TAB_SIZE * 2 + ss) / (2 * ss)) % TAB_SIZE;
        phase_trig(p0, sl, cl);
        phase_trig(p1, sr, cr);
        one  = 64'sd1 << FRAC_BITS;
        half = 64'sd1 << (FRAC_BITS - 1);
        lx  = round_div(sl, 2 * sh); lz  = round_div(cl, 2 * sh);
        rx  = round_div(sr, 2 * sh); rz  = round_div(cr, 2 * sh);
        nlx = round_div(sl, sh);     nlz = round_div(cl, sh);
        nrx = round_div(sr, sh);     nrz = round_div(cr, sh);
        yt  = round_div((longint'(rr) - 2 * longint'(i)) * one, 2 * rr);
        yb  = round_div((longint'(rr) - 2 * longint'(i) - 2) * one, 2 * rr);
        // side quad
        push_vertex(SURF_SIDE, lx, yt, lz, nlx, 0, nlz, 1'b0);
        push_vertex(SURF_SIDE, lx, yb, lz, nlx, 0, nlz, 1'b0);
        push_vertex(SURF_SIDE, rx, yt, rz, nrx, 0, nrz, 1'b0);
        push_vertex(SURF_SIDE, rx, yt, rz, nrx, 0, nrz, 1'b0);
        push_vertex(SURF_SIDE, lx, yb, lz, nlx, 0, nlz, 1'b0);
        push_vertex(SURF_SIDE, rx, yb, rz, nrx, 0, nrz, 1'b0);
        // cap ring points
        tlx = round_div(sl * longint'(i), 2 * rr * sh);
        tlz = round_div(cl * longint'(i), 2 * rr * sh);
        trx = round_div(sr * longint'(i), 2 * rr * sh);
        trz = round_div(cr * longint'(i), 2 * rr * sh);
        blx = round_div(sl * longint'(i + 1), 2 * rr * sh);
        blz = round_div(cl * longint'(i + 1), 2 * rr * sh);
        brx = round_div(sr * longint'(i + 1), 2 * rr * sh);
        brz = round_div(cr * longint'(i + 1), 2 * rr * sh);
        push_vertex(SURF_TOP, tlx, half, tlz, 0, one, 0, 1'b0);
        push_vertex(SURF_TOP, blx, half, blz, 0, one, 0, 1'b0);
        push_vertex(SURF_TOP, trx, half, trz, 0, one, 0, 1'b0);
        push_vertex(SURF_TOP, trx, half, trz, 0, one, 0, 1'b0);
        push_vertex(SURF_TOP, blx, half, blz, 0, one, 0, 1'b0);
        push_vertex(SURF_TOP, brx, half, brz, 0, one, 0, 1'b0);
        // bottom cap mirrors the top with left and right swapped
        push_vertex(SURF_BOTTOM, trx, -half, trz, 0, -one, 0, 1'b0);
        push_vertex(SURF_BOTTOM, brx, -half, brz, 0, -one, 0, 1'b0);
        push_vertex(SURF_BOTTOM, tlx, -half, tlz, 0, -one, 0, 1'b0);
        push_vertex(SURF_BOTTOM, tlx, -half, tlz, 0, -one, 0, 1'b0);
        push_vertex(SURF_BOTTOM, brx, -half, brz, 0, -one, 0, 1'b0);
        push_vertex(SURF_BOTTOM, blx, -half, blz, 0, -one, 0, 1'b1);
    endtask

    // Driver: holds start until the transfer, then feeds the next cell
    always @(posedge i_clk) begin
        logic took;
        took = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (took) begin
                tessellate_cell(i_row_index, i_wedge_index);
                void'(cell_q.pop_front());
            end
            if (!start || took) begin
                if (cell_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    start         <= 1'b1;
                    i_row_index   <= cell_q[0].row;
                    i_wedge_index <= cell_q[0].wedge;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is checked against the oldest expected vertex
    always @(posedge i_clk) begin
        vertex_t got;
        vertex_t want;
        if (i_rst_n && o_strobe) begin
            got = {o_surface, o_pos_x, o_pos_y, o_pos_z, o_norm_x, o_norm_y, o_norm_z,
                   o_index_error, o_last};
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected vertex %p", got);
            end else begin
                want = vertex_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("vertex mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc >= WDOG_LIMIT) begin
            $display("tb_cylinder_mesh_tessellator_top: done, errors");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ROW_COUNT) row_cfg = val[7:0];
        else if (idx == REG_SEGMENT_COUNT) seg_cfg = val;
    endtask

    task automatic add_cell(input int row, input int wedge);
        cell_req_t c;
        c.row   = ROW_W'(row);
        c.wedge = SEG_W'(wedge);
        cell_q.insert(cell_q.size(), c);
    endtask

    // Wait for every cell to be taken and every vertex to arrive, then let the pipe drain
    task automatic drain();
        do @(negedge i_clk); while (cell_q.size() > 0 || start || vertex_q.size() > 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Random cells, mostly inside the configured grid
    task automatic random_cells(input int n);
        int r_lim, s_lim;
        r_lim = (row_cfg < 1) ? 1 : row_cfg;
        s_lim = (seg_cfg < 3) ? 3 : seg_cfg;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                add_cell($urandom_range(255), $urandom_range(1023));
            else
                add_cell($urandom_range(r_lim - 1), $urandom_range(s_lim - 1));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_row_index   = '0;
        i_wedge_index = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_ROW_COUNT;
        i_cfg_data    = '0;
        row_cfg       = 8'd1;
        seg_cfg       = 10'd3;
        idle_pct      = 10;
        mismatches    = 0;
        quiet_cyc     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset counts: one row, three wedges
        add_cell(0, 0); add_cell(0, 1); add_cell(0, 2);
        add_cell(0, 3); add_cell(1, 0); add_cell(255, 1023);
        drain();

        // largest grid
        write_reg(REG_ROW_COUNT, 10'd255);
        write_reg(REG_SEGMENT_COUNT, 10'd1023);
        add_cell(0, 0); add_cell(254, 1022); add_cell(255, 0);
        add_cell(0, 1023); add_cell(127, 511); add_cell(170, 341);
        drain();

        // counts below the minimum clamp up; spare index must be ignored
        write_reg(REG_ROW_COUNT, 10'd0);
        write_reg(REG_SEGMENT_COUNT, 10'd1);
        write_reg(REG_SPARE, 10'h3ff);
        add_cell(0, 2); add_cell(0, 3); add_cell(1, 1);
        drain();
        write_reg(REG_SEGMENT_COUNT, 10'd2);
        add_cell(0, 2); add_cell(0, 0);
        drain();

        // random grids under each idling mode
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 10 : (ph == 1) ? 47 : 0;
            write_reg(REG_ROW_COUNT, 10'($urandom_range(1, 255)));
            write_reg(REG_SEGMENT_COUNT, 10'($urandom_range(3, 1023)));
            random_cells(27);
            drain();
            write_reg(REG_ROW_COUNT, 10'($urandom_range(1, 8)));
            write_reg(REG_SEGMENT_COUNT, 10'($urandom_range(3, 16)));
            random_cells(27);
            drain();
        end

        if (mismatches == 0) begin
            $display("tb_cylinder_mesh_tessellator_top: done, clean");
        end else begin
            $display("tb_cylinder_mesh_tessellator_top: done, errors");
        end
        $finish;
    end

endmodule
